@@ design/sata_command_descriptor_builder_core_defines.svh @@
// assertion macros for the command descriptor builder
`ifndef SATA_COMMAND_DESCRIPTOR_BUILDER_CORE_DEFINES_SVH
`define SATA_COMMAND_DESCRIPTOR_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SCDB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/scdb_pkg.sv @@
// shared types and constants of the command descriptor builder
`timescale 1ns / 1ps

package scdb_pkg;

    // sizing
    localparam int SLOT_COUNT        = 32;
    localparam int MAX_ENTRIES       = 63;
    localparam int SECTORS_PER_ENTRY = 16;
    localparam int MAX_SECTORS       = MAX_ENTRIES * SECTORS_PER_ENTRY;

    // field widths
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int LBA_W    = 48;
    localparam int SECT_W   = 16;
    localparam int FCOUNT_W = 10;
    localparam int ADDR_W   = 32;
    localparam int BC_W     = 13;

    // entry geometry
    localparam logic [ADDR_W-1:0] ENTRY_STRIDE         = 32'd8192;
    localparam logic [BC_W-1:0]   ENTRY_BYTES_LESS_ONE = 13'h1FFF;
    localparam logic [8:0]        SECTOR_BYTES_LOW     = 9'h1FF;

    // ATA opcodes
    localparam logic [7:0] OP_READ     = 8'h25;
    localparam logic [7:0] OP_WRITE    = 8'h35;
    localparam logic [7:0] OP_IDENTIFY = 8'hEC;

    // register map
    localparam logic [0:0] REG_INTERRUPT_ON_LAST = 1'b0;

    // request kinds
    typedef enum logic [1:0] {
        KIND_READ     = 2'd0,
        KIND_WRITE    = 2'd1,
        KIND_IDENTIFY = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    // result kinds
    typedef enum logic [1:0] {
        RK_HEADER    = 2'd0,
        RK_ENTRY     = 2'd1,
        RK_NO_SLOT   = 2'd2,
        RK_BAD_COUNT = 2'd3
    } t_result_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_ENTRY
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_header;
        logic emit_entry;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic error_result;
        logic last_entry;
    } t_dp_status;

endpackage

@@ design/scdb_datapath.sv @@
// request capture, slot pick and result formatting
`timescale 1ns / 1ps

module scdb_datapath (
    input  logic                        i_clk,
    input  scdb_pkg::t_dp_cmd           i_cmd,
    output scdb_pkg::t_dp_status        o_status,
    input  logic                        i_irq_on_last,
    input  logic [1:0]                  i_kind,
    input  logic [scdb_pkg::LBA_W-1:0]  i_block_address,
    input  logic [scdb_pkg::SECT_W-1:0] i_sectors_requested,
    input  logic [scdb_pkg::ADDR_W-1:0] i_buffer_address,
    input  logic [31:0]                 i_slots_active,
    input  logic [31:0]                 i_slots_issued,
    output logic [1:0]                  o_result_kind,
    output logic [scdb_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_write_flag,
    output logic [scdb_pkg::COUNT_W-1:0] o_entry_count,
    output logic [7:0]                  o_command_code,
    output logic [scdb_pkg::LBA_W-1:0]  o_fis_address,
    output logic [scdb_pkg::FCOUNT_W-1:0] o_fis_count,
    output logic                        o_lba_mode,
    output logic [scdb_pkg::ADDR_W-1:0] o_data_address,
    output logic [scdb_pkg::BC_W-1:0]   o_byte_count_less_one,
    output logic                        o_interrupt_on_done,
    output logic                        o_last
);
    import scdb_pkg::*;

    // captured request
    logic               r_found;
    logic               r_bad;
    logic               r_identify;
    logic               r_write;
    logic [SLOT_W-1:0]  r_slot;
    logic [LBA_W-1:0]   r_lba;
    logic [FCOUNT_W-1:0] r_fcount;
    logic [3:0]         r_tail;
    logic [ADDR_W-1:0]  r_addr;
    logic [COUNT_W-1:0] r_entries_left;

    // output register
    logic [1:0]          r_rk;
    logic [SLOT_W-1:0]   r_oslot;
    logic                r_owrite;
    logic [COUNT_W-1:0]  r_oec;
    logic [7:0]          r_occ;
    logic [LBA_W-1:0]    r_ofa;
    logic [FCOUNT_W-1:0] r_ofc;
    logic                r_olba;
    logic [ADDR_W-1:0]   r_oda;
    logic [BC_W-1:0]     r_obc;
    logic                r_oirq;
    logic                r_olast;

    logic [31:0]         busy;
    logic [SLOT_W-1:0]   free_slot;
    logic                free_found;
    logic [SECT_W-1:0]   count_m1;
    logic                is_identify;
    logic                count_bad;
    logic [COUNT_W-1:0]  n_entries;

    // lowest slot clear in both masks
    always_comb begin
        busy       = i_slots_active | i_slots_issued;
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy[i]) begin
                free_slot  = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // count checks and entry count
    always_comb begin
        count_m1    = i_sectors_requested - 16'd1;
        is_identify = (i_kind == KIND_IDENTIFY);
        count_bad   = (i_kind == KIND_UNUSED) ||
                      (!is_identify && ((i_sectors_requested == '0) ||
                       (i_sectors_requested > SECT_W'(MAX_SECTORS))));
        n_entries   = is_identify ? COUNT_W'(1) : (count_m1[9:4] + 6'd1);
    end

    // status to the sequencer
    always_comb begin
        o_status.error_result = !r_found || r_bad;
        o_status.last_entry   = (r_entries_left == COUNT_W'(1));
    end

    // request capture and entry walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found        <= free_found;
            r_bad          <= count_bad;
            r_identify     <= is_identify;
            r_write        <= (i_kind == KIND_WRITE);
            r_slot         <= free_slot;
            r_lba          <= i_block_address;
            r_fcount       <= i_sectors_requested[FCOUNT_W-1:0];
            r_tail         <= is_identify ? 4'd0 : count_m1[3:0];
            r_addr         <= i_buffer_address;
            r_entries_left <= n_entries;
        end else if (i_cmd.emit_entry) begin
            r_addr         <= r_addr + ENTRY_STRIDE;
            r_entries_left <= r_entries_left - COUNT_W'(1);
        end
    end

    // result formatting
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_header) begin
            r_oda   <= '0;
            r_obc   <= '0;
            r_oirq  <= 1'b0;
            if (!r_found || r_bad) begin
                r_rk     <= r_found ? RK_BAD_COUNT : RK_NO_SLOT;
                r_oslot  <= '0;
                r_owrite <= 1'b0;
                r_oec    <= '0;
                r_occ    <= '0;
                r_ofa    <= '0;
                r_ofc    <= '0;
                r_olba   <= 1'b0;
                r_olast  <= 1'b1;
            end else if (r_identify) begin
                r_rk     <= RK_HEADER;
                r_oslot  <= r_slot;
                r_owrite <= 1'b0;
                r_oec    <= r_entries_left;
                r_occ    <= OP_IDENTIFY;
                r_ofa    <= '0;
                r_ofc    <= '0;
                r_olba   <= 1'b0;
                r_olast  <= 1'b0;
            end else begin
                r_rk     <= RK_HEADER;
                r_oslot  <= r_slot;
                r_owrite <= r_write;
                r_oec    <= r_entries_left;
                r_occ    <= r_write ? OP_WRITE : OP_READ;
                r_ofa    <= r_lba;
                r_ofc    <= r_fcount;
                r_olba   <= 1'b1;
                r_olast  <= 1'b0;
            end
        end else if (i_cmd.emit_entry) begin
            r_rk     <= RK_ENTRY;
            r_oslot  <= r_slot;
            r_owrite <= 1'b0;
            r_oec    <= '0;
            r_occ    <= '0;
            r_ofa    <= '0;
            r_ofc    <= '0;
            r_olba   <= 1'b0;
            r_oda    <= r_addr;
            if (o_status.last_entry) begin
                r_obc   <= {r_tail, SECTOR_BYTES_LOW};
                r_oirq  <= r_identify | i_irq_on_last;
                r_olast <= 1'b1;
            end else begin
                r_obc   <= ENTRY_BYTES_LESS_ONE;
                r_oirq  <= 1'b0;
                r_olast <= 1'b0;
            end
        end
    end

    assign o_result_kind         = r_rk;
    assign o_slot                = r_oslot;
    assign o_write_flag          = r_owrite;
    assign o_entry_count         = r_oec;
    assign o_command_code        = r_occ;
    assign o_fis_address         = r_ofa;
    assign o_fis_count           = r_ofc;
    assign o_lba_mode            = r_olba;
    assign o_data_address        = r_oda;
    assign o_byte_count_less_one = r_obc;
    assign o_interrupt_on_done   = r_oirq;
    assign o_last                = r_olast;

endmodule

@@ design/scdb_controller.sv @@
// sequencer: capture, header, one entry per unstalled cycle
`timescale 1ns / 1ps

module scdb_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  scdb_pkg::t_dp_status i_status,
    output scdb_pkg::t_dp_cmd    o_cmd
);
    import scdb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // output register can take a new result
    assign out_free = !r_out_valid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_HEADER;
            end
            ST_HEADER: begin
                if (out_free) n_state = i_status.error_result ? ST_IDLE : ST_ENTRY;
            end
            ST_ENTRY: begin
                if (out_free && i_status.last_entry) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands and handshake outputs
    always_comb begin
        o_cmd       = '0;
        o_stall     = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_HEADER: begin
                o_cmd.emit_header = out_free;
            end
            ST_ENTRY: begin
                o_cmd.emit_entry = out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
        n_out_valid = (o_cmd.emit_header || o_cmd.emit_entry) ? 1'b1 :
                      (i_stall ? r_out_valid : 1'b0);
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ design/sata_command_descriptor_builder_core.sv @@
// top level of the command descriptor builder
//
// channel   direction  handshake           payload
// request   in         i_valid / o_stall   kind, block address, count, buffer, slot masks
// result    out        o_valid / i_stall   header, scatter entry or error code
// config    in         APB psel/penable    interrupt_on_last at byte address 0
//
// a read or write of n scatter entries runs through capture of the request, the
// header and then the n entries; identify gives a header and one entry, an error one result.
// the single output register emits at most one result per cycle.
// reset clears the sequencer and the output valid, interrupt_on_last resets to 1.
// a stalled result holds the output register; the sequencer waits in header or
// entry until it is taken, and in idle still captures the next request.
`timescale 1ns / 1ps

`include "sata_command_descriptor_builder_core_defines.svh"

module sata_command_descriptor_builder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // request
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [scdb_pkg::LBA_W-1:0]    i_block_address,
    input  logic [scdb_pkg::SECT_W-1:0]   i_sectors_requested,
    input  logic [scdb_pkg::ADDR_W-1:0]   i_buffer_address,
    input  logic [31:0]                   i_slots_active,
    input  logic [31:0]                   i_slots_issued,
    // result
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_result_kind,
    output logic [scdb_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_write_flag,
    output logic [scdb_pkg::COUNT_W-1:0]  o_entry_count,
    output logic [7:0]                    o_command_code,
    output logic [scdb_pkg::LBA_W-1:0]    o_fis_address,
    output logic [scdb_pkg::FCOUNT_W-1:0] o_fis_count,
    output logic                          o_lba_mode,
    output logic [scdb_pkg::ADDR_W-1:0]   o_data_address,
    output logic [scdb_pkg::BC_W-1:0]     o_byte_count_less_one,
    output logic                          o_interrupt_on_done,
    output logic                          o_last
);
    import scdb_pkg::*;

    logic       r_irq_on_last;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_on_last <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[2] == REG_INTERRUPT_ON_LAST)) begin
            r_irq_on_last <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INTERRUPT_ON_LAST) ? {31'd0, r_irq_on_last} : 32'd0;

    // sequencer
    scdb_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // datapath
    scdb_datapath u_dp (
        .i_clk                 (i_clk),
        .i_cmd                 (dp_cmd),
        .o_status              (dp_status),
        .i_irq_on_last         (r_irq_on_last),
        .i_kind                (i_kind),
        .i_block_address       (i_block_address),
        .i_sectors_requested   (i_sectors_requested),
        .i_buffer_address      (i_buffer_address),
        .i_slots_active        (i_slots_active),
        .i_slots_issued        (i_slots_issued),
        .o_result_kind         (o_result_kind),
        .o_slot                (o_slot),
        .o_write_flag          (o_write_flag),
        .o_entry_count         (o_entry_count),
        .o_command_code        (o_command_code),
        .o_fis_address         (o_fis_address),
        .o_fis_count           (o_fis_count),
        .o_lba_mode            (o_lba_mode),
        .o_data_address        (o_data_address),
        .o_byte_count_less_one (o_byte_count_less_one),
        .o_interrupt_on_done   (o_interrupt_on_done),
        .o_last                (o_last)
    );

    // one request at a time
    `SCDB_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "request accepted while busy")

    // a header is never the final result
    `SCDB_ASSERT_NOW(a_header_not_last, i_clk, i_rst_n, o_valid && (o_result_kind == RK_HEADER), !o_last, "header marked last")

    // errors are single results with no slot
    `SCDB_ASSERT_NOW(a_error_shape, i_clk, i_rst_n, o_valid && ((o_result_kind == RK_NO_SLOT) || (o_result_kind == RK_BAD_COUNT)), o_last && (o_slot == '0), "malformed error result")

    // interrupt bit only on the final entry
    `SCDB_ASSERT_NOW(a_irq_on_last, i_clk, i_rst_n, o_valid && o_interrupt_on_done, o_last && (o_result_kind == RK_ENTRY), "interrupt on non-final result")

endmodule
